@@ rtl/exm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-match table package
// Shared types, codes and defaults for the 48-bit key exact-match table.
// ----------------------------------------------------------------------------
package exm_pkg;

   localparam int KEY_WIDTH        = 48;
   localparam int PORT_VALUE_WIDTH = 32;
   localparam int DEF_ENTRIES      = 256;
   localparam int DEF_VALUE_WIDTH  = 32;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_PRESENT  = 2'd2,
      STATUS_FULL     = 2'd3
   } insert_status_type;

   typedef struct packed {
      logic                        req_type;
      logic [KEY_WIDTH-1:0]        match_key;
      logic [PORT_VALUE_WIDTH-1:0] entry_value;
   } exm_request_type;

   typedef struct packed {
      logic                        hit;
      logic [PORT_VALUE_WIDTH-1:0] found_value;
      insert_status_type           insert_status;
   } exm_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_DECIDE
   } exm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic read;
      logic finish;
   } exm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic table_empty;
      logic scan_last;
   } exm_status_type;

endpackage

@@ rtl/exact_match_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-match table
// 48-bit key lookup/insert table with a sequential scan of the filled entries.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data (lookup or insert, key, value) with start
//   high; the request is taken at a rising edge where start is high and busy
//   is low. busy stays high while the request is being worked on.
//   Result channel: rsp_strobe is high for exactly one cycle with rsp_data
//   (hit, found value, insert status). The receiver cannot hold it off.
//   Scan: the filled entries are scanned one per cycle through the single
//   read port of the entry memory. busy drops in the result cycle, so the
//   next request may be taken at the edge that ends it.
//   Inserts append at the fill count; entries below the count are the valid
//   ones, so reset only clears the count and no clearing pass is needed.
//   After reset the table is empty and the block is idle.
// ----------------------------------------------------------------------------
module exact_match_table #(
   parameter int ENTRIES     = exm_pkg::DEF_ENTRIES,
   parameter int VALUE_WIDTH = exm_pkg::DEF_VALUE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  exm_pkg::exm_request_type req_data,
   output logic                    rsp_strobe,
   output exm_pkg::exm_result_type  rsp_data
);
   import exm_pkg::*;

   exm_cmd_type    cmd;
   exm_status_type status;

   // sequence each request: load, then scan and drain the last compare unless the table is empty, finish
   exm_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // hold the request, scan the entry memory, build and register the result
   exm_datapath #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/exm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-match table datapath
// Entry memory, fill count, scan address, key compare and result register.
// ----------------------------------------------------------------------------
module exm_datapath #(
   parameter int ENTRIES     = exm_pkg::DEF_ENTRIES,
   parameter int VALUE_WIDTH = exm_pkg::DEF_VALUE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  exm_pkg::exm_request_type req_data,
   input  exm_pkg::exm_cmd_type     cmd,
   output exm_pkg::exm_status_type  status,
   output logic                    rsp_strobe,
   output exm_pkg::exm_result_type  rsp_data
);
   import exm_pkg::*;

   localparam int IW    = $clog2(ENTRIES);
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int VW_LO = (VALUE_WIDTH < PORT_VALUE_WIDTH) ? VALUE_WIDTH : PORT_VALUE_WIDTH;

   logic [KEY_WIDTH-1:0]   key_mem [ENTRIES];
   logic [VALUE_WIDTH-1:0] val_mem [ENTRIES];

   exm_request_type        req_ff;
   logic [IW-1:0]          scan_addr_ff, scan_addr_in;
   logic                   rd_pending_ff;
   logic [KEY_WIDTH-1:0]   rd_key_ff;
   logic [VALUE_WIDTH-1:0] rd_val_ff;
   logic                   match_ff, match_in;
   logic [VALUE_WIDTH-1:0] match_val_ff, match_val_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   strobe_ff;
   exm_result_type         rsp_ff, rsp_in;

   logic                   hit_now;
   logic                   do_write;
   logic [VALUE_WIDTH-1:0] wr_val;
   logic [PORT_VALUE_WIDTH-1:0] match_val_port;

   assign hit_now = rd_pending_ff && (rd_key_ff == req_ff.match_key);
   assign do_write = cmd.finish && (req_ff.req_type == REQ_INSERT) && !match_ff
                     && (count_ff < CW'(ENTRIES));

   assign status.table_empty = (count_ff == '0);
   assign status.scan_last   = ((CW'(scan_addr_ff) + CW'(1)) == count_ff);

   always_comb begin
      wr_val                  = '0;
      wr_val[VW_LO-1:0]       = req_ff.entry_value[VW_LO-1:0];
      match_val_port          = '0;
      match_val_port[VW_LO-1:0] = match_val_ff[VW_LO-1:0];
   end

   always_comb begin
      scan_addr_in = scan_addr_ff;
      match_in     = match_ff;
      match_val_in = match_val_ff;
      count_in     = count_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
         match_in     = 1'b0;
      end else if (cmd.read) begin
         scan_addr_in = scan_addr_ff + IW'(1);
      end
      if (hit_now) begin
         match_in     = 1'b1;
         match_val_in = rd_val_ff;
      end
      if (do_write) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.hit           = match_ff;
      rsp_in.found_value   = match_ff ? match_val_port : '0;
      rsp_in.insert_status = STATUS_NONE;
      if (req_ff.req_type == REQ_INSERT) begin
         priority if (match_ff) begin
            rsp_in.insert_status = STATUS_PRESENT;
         end else if (do_write) begin
            rsp_in.insert_status = STATUS_INSERTED;
         end else begin
            rsp_in.insert_status = STATUS_FULL;
         end
      end
   end

   // entry memory: one write port at the fill count, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         key_mem[count_ff[IW-1:0]] <= req_ff.match_key;
         val_mem[count_ff[IW-1:0]] <= wr_val;
      end
      rd_key_ff <= key_mem[scan_addr_ff];
      rd_val_ff <= val_mem[scan_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_pending_ff <= 1'b0;
         match_ff      <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_pending_ff <= cmd.read;
         match_ff      <= match_in;
         strobe_ff     <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
      scan_addr_ff <= scan_addr_in;
      match_val_ff <= match_val_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ rtl/exm_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-match table controller
// Sequences load, scan, compare drain and result/insert for each request.
// ----------------------------------------------------------------------------
module exm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  exm_pkg::exm_status_type status,
   output logic                   busy,
   output exm_pkg::exm_cmd_type    cmd
);
   import exm_pkg::*;

   exm_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.table_empty ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN:   cmd.read   = 1'b1;
         ST_WAIT:   cmd        = '0;
         ST_DECIDE: cmd.finish = 1'b1;
         default:   cmd        = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/exm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-match table checker
// Port-level properties of the request/result sequencing, bound to the top.
// ----------------------------------------------------------------------------
module exm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input exm_pkg::exm_result_type  rsp_data
);
   import exm_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe)
      else $error("request finished without a result");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.hit |-> rsp_data.found_value == '0
         && rsp_data.insert_status != STATUS_PRESENT)
      else $error("miss result carries a value or present status");

endmodule

bind exact_match_table exm_checker u_exm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

@@ tb/tb_exact_match_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exact-match table testbench
// Drives lookup and insert requests into the 48-bit key table, works out the
// result of each taken request with its own copy of the table, and compares
// every result strobe field by field against the oldest outstanding result.
// A short directed table covers the key and value extremes, new and present
// inserts. A long random run then fills the table to capacity and keeps going
// with hits, near misses, duplicate inserts and inserts into a full table.
// ----------------------------------------------------------------------------
module tb_exact_match_table;
   import exm_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int ENTRIES        = DEF_ENTRIES;
   localparam int VALUE_WIDTH    = DEF_VALUE_WIDTH;
   localparam int RANDOM_ITEMS   = 1130;
   localparam int MAX_GAP        = 12;
   localparam int MAX_BURST      = 40;
   localparam int REPORT_LIMIT   = 10;
   // watchdog limit, built from a full scan plus the longest sender gap
   localparam int WATCHDOG_LIMIT = 4 * (ENTRIES + 3 + MAX_GAP) + 64;
   localparam int DRAIN_CYCLES   = ENTRIES + 8;
   localparam logic [PORT_VALUE_WIDTH-1:0] VALUE_MASK =
      {PORT_VALUE_WIDTH{1'b1}} >> (PORT_VALUE_WIDTH - VALUE_WIDTH);
   localparam logic [KEY_WIDTH-1:0] ALL_ONES_KEY = {KEY_WIDTH{1'b1}};
   // locally administered prefix so that many keys share their upper bytes
   localparam logic [23:0] SHARED_PREFIX = 24'h02_A0_C4;

   typedef struct packed {
      exm_request_type request;
      logic            has_want;
      exm_result_type  want;
   } stimulus_row_type;

   // Directed rows: the result is typed in where it is obvious, otherwise the
   // row is checked against the table model.
   localparam int DIRECTED_ROWS = 16;
   localparam stimulus_row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty table: both key extremes miss
      '{'{REQ_LOOKUP, 48'h0, 32'h0},                  1'b1, '{1'b0, 32'h0, STATUS_NONE}},
      '{'{REQ_LOOKUP, ALL_ONES_KEY, 32'hFFFF_FFFF},   1'b1, '{1'b0, 32'h0, STATUS_NONE}},
      // fill the extremes
      '{'{REQ_INSERT, 48'h0, 32'hFFFF_FFFF},          1'b1, '{1'b0, 32'h0, STATUS_INSERTED}},
      '{'{REQ_INSERT, ALL_ONES_KEY, 32'h0},           1'b1, '{1'b0, 32'h0, STATUS_INSERTED}},
      // hits return the stored values
      '{'{REQ_LOOKUP, 48'h0, 32'h0},                  1'b1, '{1'b1, 32'hFFFF_FFFF, STATUS_NONE}},
      '{'{REQ_LOOKUP, ALL_ONES_KEY, 32'h1234_5678},   1'b1, '{1'b1, 32'h0, STATUS_NONE}},
      // duplicate insert leaves the old value in place
      '{'{REQ_INSERT, 48'h0, 32'h1234_5678},          1'b1, '{1'b1, 32'hFFFF_FFFF, STATUS_PRESENT}},
      '{'{REQ_LOOKUP, 48'h0, 32'h0},                  1'b1, '{1'b1, 32'hFFFF_FFFF, STATUS_NONE}},
      '{'{REQ_INSERT, 48'h0000_0000_0001, 32'h8000_0001}, 1'b1,
        '{1'b0, 32'h0, STATUS_INSERTED}},
      // top bit alone is a different key
      '{'{REQ_LOOKUP, 48'h8000_0000_0000, 32'h0},     1'b1, '{1'b0, 32'h0, STATUS_NONE}},
      '{'{REQ_INSERT, 48'hA5A5_A5A5_A5A5, 32'h5A5A_5A5A}, 1'b0, '0},
      '{'{REQ_LOOKUP, 48'hA5A5_A5A5_A5A5, 32'hDEAD_BEEF}, 1'b0, '0},
      '{'{REQ_LOOKUP, 48'h0000_0000_0001, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{REQ_INSERT, 48'h7FFF_FFFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0},
      '{'{REQ_LOOKUP, 48'hFFFF_FFFF_FFFE, 32'h0},     1'b0, '0},
      '{'{REQ_INSERT, 48'h7FFF_FFFF_FFFF, 32'h0},     1'b0, '0}
   };

   // DUT interface, known from time zero
   logic            clock      = 1'b0;
   logic            reset      = 1'b1;
   logic            start      = 1'b0;
   logic            busy;
   exm_request_type req_data   = '0;
   logic            rsp_strobe;
   exm_result_type  rsp_data;

   // typed expectation that travels with the request being offered
   logic            row_has_want = 1'b0;
   exm_result_type  row_want     = '0;

   // table model state
   logic [KEY_WIDTH-1:0]        model_keys   [ENTRIES];
   logic [PORT_VALUE_WIDTH-1:0] model_values [ENTRIES];
   int                          model_count = 0;

   exm_result_type pending_results [$];

   int mismatches    = 0;
   int quiet_cycles  = 0;
   int n_lookups     = 0;
   int n_hits        = 0;
   int n_inserted    = 0;
   int n_present     = 0;
   int n_full        = 0;

   exact_match_table #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one request to the table model: search the filled entries, then
   // append on an insert of a new key while there is room.
   function automatic exm_result_type lookup_or_insert(input exm_request_type r);
      exm_result_type res;
      int             idx;
      int             i;
      res = '0;
      res.insert_status = STATUS_NONE;
      idx = -1;
      for (i = 0; i < model_count; i++) begin
         if (idx < 0 && model_keys[i] == r.match_key) idx = i;
      end
      if (idx >= 0) begin
         res.hit         = 1'b1;
         res.found_value = model_values[idx];
      end
      if (r.req_type == REQ_INSERT) begin
         if (idx >= 0) begin
            res.insert_status = STATUS_PRESENT;
         end else if (model_count >= ENTRIES) begin
            res.insert_status = STATUS_FULL;
         end else begin
            model_keys[model_count]   = r.match_key;
            model_values[model_count] = r.entry_value & VALUE_MASK;
            model_count++;
            res.insert_status = STATUS_INSERTED;
         end
      end
      return res;
   endfunction

   // Offer one request and hold it until taken. Start is left high so that a
   // request that follows at once keeps it high without a lower/raise pair.
   task automatic send_request(input exm_request_type r, input logic has_want,
                               input exm_result_type want);
      req_data     <= r;
      row_has_want <= has_want;
      row_want     <= want;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and hold off until every outstanding result is back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Monitor: check the result strobe first, then record a newly taken
   // request, so a result and the next request on the same edge stay ordered.
   always @(posedge clock) begin
      exm_result_type predicted;
      exm_result_type oldest;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("[%0t] unexpected result: hit=%0b value=%h status=%s",
                        $realtime, rsp_data.hit, rsp_data.found_value,
                        rsp_data.insert_status.name());
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_data.hit !== oldest.hit ||
                rsp_data.found_value !== oldest.found_value ||
                rsp_data.insert_status !== oldest.insert_status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("[%0t] result differs: hit %0b/%0b value %h/%h status %s/%s",
                           $realtime, oldest.hit, rsp_data.hit,
                           oldest.found_value, rsp_data.found_value,
                           oldest.insert_status.name(), rsp_data.insert_status.name());
            end
         end
      end
      if (!reset && start && !busy) begin
         predicted = lookup_or_insert(req_data);
         pending_results.push_back(row_has_want ? row_want : predicted);
         if (req_data.req_type == REQ_LOOKUP) n_lookups++;
         if (predicted.hit) n_hits++;
         case (predicted.insert_status)
            STATUS_INSERTED: n_inserted++;
            STATUS_PRESENT:  n_present++;
            STATUS_FULL:     n_full++;
            default: ;
         endcase
      end
   end

   // Watchdog: reset the count on any handshake, give up after a long silence.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding",
                  pending_results.size());
         $display("exact_match_table: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      exm_request_type  r;
      logic [63:0]      rnd;
      int               burst_left;
      int               kind;
      int               pick;
      burst_left = 0;

      // hold reset, release it on an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, a small random gap now and then
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_request(DIRECTED[row].request, DIRECTED[row].has_want,
                      DIRECTED[row].want);
         if ($urandom_range(3, 0) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clock);
         end
      end
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // close a burst: idle for a random gap, sometimes none at all
         if (burst_left == 0) begin
            burst_left = $urandom_range(MAX_BURST, 1);
            if ($urandom_range(3, 0) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(MAX_GAP, 1)) @(posedge clock);
            end
         end
         burst_left--;

         // halfway through, let the block run dry once
         if (n == RANDOM_ITEMS / 2) drain_results();

         rnd              = {$urandom, $urandom};
         r.match_key      = rnd[KEY_WIDTH-1:0];
         r.entry_value    = $urandom;
         r.req_type       = REQ_LOOKUP;
         pick             = (model_count > 0) ? $urandom_range(model_count - 1, 0) : 0;
         kind             = $urandom_range(99, 0);
         if (kind < 35) begin
            // new key, a quarter of them under a shared prefix
            r.req_type = REQ_INSERT;
            if ($urandom_range(3, 0) == 0) r.match_key = {SHARED_PREFIX, rnd[23:0]};
         end else if (kind < 50) begin
            // duplicate insert of a stored key
            r.req_type = REQ_INSERT;
            if (model_count > 0) r.match_key = model_keys[pick];
         end else if (kind < 80) begin
            // lookup of a stored key
            if (model_count > 0) r.match_key = model_keys[pick];
         end else if (kind < 90) begin
            // near miss: a stored key with one bit flipped
            if (model_count > 0)
               r.match_key = model_keys[pick] ^ (48'h1 << $urandom_range(KEY_WIDTH - 1, 0));
         end
         send_request(r, 1'b0, '0);
      end

      // wait out everything in flight, then a full scan more for stragglers
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d lookups (%0d hits over all requests), %0d inserts stored,",
               n_lookups, n_hits, n_inserted);
      $display("%0d duplicate inserts and %0d inserts refused by a full table (%0d/%0d)",
               n_present, n_full, model_count, ENTRIES);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("exact_match_table: match");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  pending_results.size());
         $display("exact_match_table: mismatch");
      end
      $finish;
   end

endmodule
